### sv/rrgb_pkg.sv
package rrgb_pkg;

    localparam int FRAC_BITS = 24;

    localparam int SW     = 48;            // sample width
    localparam int CW     = 42;            // range register width
    localparam int PW     = 25;            // gain / bias register width
    localparam int XW     = FRAC_BITS + 1; // unsigned value in [0, ONE]
    localparam int VW     = 64;            // wide signed working value
    localparam int ADDR_W = 6;
    localparam int DATA_W = 64;

    localparam int DIV_QW = 63;
    localparam int DIV_DW = (2 * FRAC_BITS + 2 > CW + 1) ? 2 * FRAC_BITS + 2 : CW + 1;
    localparam int DIV_NW = DIV_QW + DIV_DW;

    localparam logic [XW-1:0] ONE  = {1'b1, {FRAC_BITS{1'b0}}};
    localparam logic [XW-1:0] HALF = ONE >> 1;
    localparam logic [XW-1:0] EPS  = XW'(((longint'(1) << FRAC_BITS) + 50000) / 100000);
    localparam logic [XW-1:0] T999 = XW'(((longint'(1) << FRAC_BITS) * 999 + 500) / 1000);

    localparam logic [DIV_QW-1:0] VSAT = DIV_QW'(1) << 62;

    localparam logic signed [VW-1:0] S48_MAX = VW'((longint'(1) << (SW - 1)) - 1);
    localparam logic signed [VW-1:0] S48_MIN = -S48_MAX - VW'(1);

    localparam logic [1:0] MODE_PLAIN = 2'd0;
    localparam logic [1:0] MODE_CLAMP = 2'd1;
    localparam logic [1:0] MODE_WRAP  = 2'd2;

    localparam logic [2:0] REG_IN_LOW   = 3'd0;
    localparam logic [2:0] REG_IN_HIGH  = 3'd1;
    localparam logic [2:0] REG_OUT_LOW  = 3'd2;
    localparam logic [2:0] REG_OUT_HIGH = 3'd3;
    localparam logic [2:0] REG_GAIN     = 3'd4;
    localparam logic [2:0] REG_BIAS     = 3'd5;
    localparam logic [2:0] REG_MODE     = 3'd6;

    typedef struct packed {
        logic [CW-1:0] in_low;
        logic [CW-1:0] in_high;
        logic [CW-1:0] out_low;
        logic [CW-1:0] out_high;
        logic [PW-1:0] gain;
        logic [PW-1:0] bias;
        logic [1:0]    mode;
    } cfg_t;

    typedef struct packed {
        logic                 last;
        logic                 narrow;
        logic                 interior;
        logic                 neg;
        logic                 domod;
        logic                 hi;
        logic                 zero;
        logic [FRAC_BITS-1:0] n;
        logic [VW-1:0]        val;
    } side_t;

    function automatic logic signed [VW-1:0] sx_cfg(input logic [CW-1:0] v);
        return VW'($signed(v));
    endfunction

    function automatic logic [XW-1:0] clamp_one(input logic [PW-1:0] v);
        if (longint'(v) > longint'(ONE))
            return ONE;
        return XW'(v);
    endfunction

endpackage

### sv/rrgb_regs.sv
module rrgb_regs (
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         psel,
    input  logic                         penable,
    input  logic                         pwrite,
    input  logic [rrgb_pkg::ADDR_W-1:0]  paddr,
    input  logic [rrgb_pkg::DATA_W-1:0]  pwdata,
    output logic [rrgb_pkg::DATA_W-1:0]  prdata,
    output logic                         pready,
    output rrgb_pkg::cfg_t               cfg
);

    rrgb_pkg::cfg_t cfg_reg;
    logic [2:0]     idx;
    logic           wr;

    assign idx    = paddr[rrgb_pkg::ADDR_W-1:3];
    assign wr     = psel && penable && pwrite;
    assign pready = 1'b1;
    assign cfg    = cfg_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg <= '0;
        end
        else if (wr)
        begin
            case (idx)
                rrgb_pkg::REG_IN_LOW:   cfg_reg.in_low   <= pwdata[rrgb_pkg::CW-1:0];
                rrgb_pkg::REG_IN_HIGH:  cfg_reg.in_high  <= pwdata[rrgb_pkg::CW-1:0];
                rrgb_pkg::REG_OUT_LOW:  cfg_reg.out_low  <= pwdata[rrgb_pkg::CW-1:0];
                rrgb_pkg::REG_OUT_HIGH: cfg_reg.out_high <= pwdata[rrgb_pkg::CW-1:0];
                rrgb_pkg::REG_GAIN:     cfg_reg.gain     <= pwdata[rrgb_pkg::PW-1:0];
                rrgb_pkg::REG_BIAS:     cfg_reg.bias     <= pwdata[rrgb_pkg::PW-1:0];
                rrgb_pkg::REG_MODE:     cfg_reg.mode     <= pwdata[1:0];
                default:                ;
            endcase
        end
    end

    always_comb
    begin
        case (idx)
            rrgb_pkg::REG_IN_LOW:   prdata = rrgb_pkg::DATA_W'(cfg_reg.in_low);
            rrgb_pkg::REG_IN_HIGH:  prdata = rrgb_pkg::DATA_W'(cfg_reg.in_high);
            rrgb_pkg::REG_OUT_LOW:  prdata = rrgb_pkg::DATA_W'(cfg_reg.out_low);
            rrgb_pkg::REG_OUT_HIGH: prdata = rrgb_pkg::DATA_W'(cfg_reg.out_high);
            rrgb_pkg::REG_GAIN:     prdata = rrgb_pkg::DATA_W'(cfg_reg.gain);
            rrgb_pkg::REG_BIAS:     prdata = rrgb_pkg::DATA_W'(cfg_reg.bias);
            rrgb_pkg::REG_MODE:     prdata = rrgb_pkg::DATA_W'(cfg_reg.mode);
            default:                prdata = '0;
        endcase
    end

endmodule

### sv/rrgb_div.sv
module rrgb_div (
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         valid_in,
    input  logic [rrgb_pkg::DIV_NW-1:0]  num,
    input  logic [rrgb_pkg::DIV_DW-1:0]  den,
    input  rrgb_pkg::side_t              side_in,
    output logic                         valid_out,
    output logic [rrgb_pkg::DIV_QW-1:0]  quo,
    output logic [rrgb_pkg::DIV_DW-1:0]  rem,
    output logic                         ovf,
    output rrgb_pkg::side_t              side_out
);

    localparam int QW = rrgb_pkg::DIV_QW;
    localparam int DW = rrgb_pkg::DIV_DW;
    localparam int NW = rrgb_pkg::DIV_NW;

    logic            valid_reg [0:QW];
    logic [DW-1:0]   rem_reg   [0:QW];
    logic [DW-1:0]   rem_next  [0:QW];
    logic [QW-1:0]   nq_reg    [0:QW];
    logic [QW-1:0]   nq_next   [0:QW];
    logic [DW-1:0]   den_reg   [0:QW];
    logic            ovf_reg   [0:QW];
    rrgb_pkg::side_t side_reg  [0:QW];
    logic [DW:0]     trial     [1:QW];

    // one restoring step per stage; quotient bits shift in behind the dividend bits
    always_comb
    begin
        rem_next[0] = num[NW-1:QW];
        nq_next[0]  = num[QW-1:0];
        for (int k = 1; k <= QW; k++)
        begin
            trial[k] = {rem_reg[k-1], nq_reg[k-1][QW-1]};
            if (trial[k] >= {1'b0, den_reg[k-1]})
            begin
                rem_next[k] = DW'(trial[k] - {1'b0, den_reg[k-1]});
                nq_next[k]  = {nq_reg[k-1][QW-2:0], 1'b1};
            end
            else
            begin
                rem_next[k] = trial[k][DW-1:0];
                nq_next[k]  = {nq_reg[k-1][QW-2:0], 1'b0};
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int k = 0; k <= QW; k++)
                valid_reg[k] <= 1'b0;
        end
        else
        begin
            valid_reg[0] <= valid_in;
            for (int k = 1; k <= QW; k++)
                valid_reg[k] <= valid_reg[k-1];
        end
    end

    always_ff @(posedge clk)
    begin
        rem_reg[0]  <= rem_next[0];
        nq_reg[0]   <= nq_next[0];
        den_reg[0]  <= den;
        ovf_reg[0]  <= (num[NW-1:QW] >= den);
        side_reg[0] <= side_in;
        for (int k = 1; k <= QW; k++)
        begin
            rem_reg[k]  <= rem_next[k];
            nq_reg[k]   <= nq_next[k];
            den_reg[k]  <= den_reg[k-1];
            ovf_reg[k]  <= ovf_reg[k-1];
            side_reg[k] <= side_reg[k-1];
        end
    end

    assign valid_out = valid_reg[QW];
    assign quo       = nq_reg[QW];
    assign rem       = rem_reg[QW];
    assign ovf       = ovf_reg[QW];
    assign side_out  = side_reg[QW];

    a_div_latency: assert property (@(posedge clk) disable iff (!rst_n)
        valid_out |-> $past(valid_in, QW + 1))
        else $error("divider produced a transaction that never entered");

    a_div_rem: assert property (@(posedge clk) disable iff (!rst_n)
        (valid_out && !ovf) |-> (rem < den_reg[QW]))
        else $error("divider remainder not below divisor");

endmodule

### sv/rrgb_curve.sv
module rrgb_curve (
    input  logic                      clk,
    input  logic                      rst_n,
    input  logic                      valid_in,
    input  logic [rrgb_pkg::XW-1:0]   x,
    input  rrgb_pkg::side_t           side_in,
    input  logic                      sch,
    input  logic [rrgb_pkg::XW-1:0]   param,
    output logic                      valid_out,
    output logic [rrgb_pkg::XW-1:0]   y,
    output rrgb_pkg::side_t           side_out
);

    localparam int XW = rrgb_pkg::XW;
    localparam int F  = rrgb_pkg::FRAC_BITS;
    localparam int QW = rrgb_pkg::DIV_QW;
    localparam int DW = rrgb_pkg::DIV_DW;
    localparam int NW = rrgb_pkg::DIV_NW;

    // pre-stage: pick the segment of the gain curve
    logic            hi;
    logic [XW:0]     x2;
    logic [XW-1:0]   xx;
    logic [XW-1:0]   p;

    logic            valid1_reg;
    logic [XW-1:0]   p1_reg;
    logic [XW-1:0]   xx1_reg;
    rrgb_pkg::side_t side1_reg;
    rrgb_pkg::side_t side1_next;

    logic [XW-1:0]   omx;
    logic [XW:0]     p2;
    logic            lowb;
    logic [XW-1:0]   coef;

    logic              valid2_reg;
    logic [2*XW-1:0]   proda_reg;
    logic [2*XW-1:0]   prodb_reg;
    logic [XW-1:0]     p2_reg;
    logic              lowb_reg;
    rrgb_pkg::side_t   side2_reg;
    rrgb_pkg::side_t   side2_next;

    logic [2*XW-1:0]   pone;
    logic [2*XW-1:0]   den2;
    logic [NW-1:0]     num2;

    logic              dvalid;
    logic [QW-1:0]     dquo;
    logic [DW-1:0]     drem;
    logic              dovf;
    rrgb_pkg::side_t   dside;

    logic [XW-1:0]     q;
    logic [XW-1:0]     y_next;
    logic              valid_out_reg;
    logic [XW-1:0]     y_reg;
    rrgb_pkg::side_t   side_out_reg;

    always_comb
    begin
        hi = sch && (x >= rrgb_pkg::HALF);
        x2 = {x, 1'b0};
        if (!sch)
            xx = x;
        else if (hi)
            xx = XW'(x2 - (XW + 1)'(rrgb_pkg::ONE));
        else
            xx = XW'(x2);
        p = hi ? rrgb_pkg::ONE - param : param;
        side1_next    = side_in;
        side1_next.hi = hi;
    end

    always_comb
    begin
        omx  = rrgb_pkg::ONE - xx1_reg;
        p2   = {p1_reg, 1'b0};
        lowb = p2 <= (XW + 1)'(rrgb_pkg::ONE);
        coef = lowb ? XW'((XW + 1)'(rrgb_pkg::ONE) - p2) : XW'(p2 - (XW + 1)'(rrgb_pkg::ONE));
    end

    always_comb
    begin
        pone = (2 * XW)'(p2_reg) << F;
        den2 = lowb_reg ? prodb_reg + pone : pone - prodb_reg;
        num2 = NW'(proda_reg) << F;
        side2_next      = side2_reg;
        side2_next.zero = (den2 == '0);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid1_reg    <= 1'b0;
            valid2_reg    <= 1'b0;
            valid_out_reg <= 1'b0;
        end
        else
        begin
            valid1_reg    <= valid_in;
            valid2_reg    <= valid1_reg;
            valid_out_reg <= dvalid;
        end
    end

    always_ff @(posedge clk)
    begin
        p1_reg       <= p;
        xx1_reg      <= xx;
        side1_reg    <= side1_next;
        proda_reg    <= xx1_reg * p1_reg;
        prodb_reg    <= coef * omx;
        p2_reg       <= p1_reg;
        lowb_reg     <= lowb;
        side2_reg    <= side1_reg;
        y_reg        <= y_next;
        side_out_reg <= dside;
    end

    rrgb_div u_div (
        .clk       (clk),
        .rst_n     (rst_n),
        .valid_in  (valid2_reg),
        .num       (num2),
        .den       (DW'(den2)),
        .side_in   (side2_next),
        .valid_out (dvalid),
        .quo       (dquo),
        .rem       (drem),
        .ovf       (dovf),
        .side_out  (dside)
    );

    always_comb
    begin
        if (dside.zero)
            q = '0;
        else if (dovf || dquo > QW'(rrgb_pkg::ONE))
            q = rrgb_pkg::ONE;
        else
            q = XW'(dquo);
        if (!sch)
            y_next = q;
        else if (dside.hi)
            y_next = (q >> 1) + rrgb_pkg::HALF;
        else
            y_next = q >> 1;
    end

    assign valid_out = valid_out_reg;
    assign y         = y_reg;
    assign side_out  = side_out_reg;

    a_curve_range: assert property (@(posedge clk) disable iff (!rst_n)
        valid_out |-> (y <= rrgb_pkg::ONE))
        else $error("curve output above one");

endmodule

### sv/range_remap_gain_bias.sv
// Throughput: one transaction per cycle; busy stays low and start is taken every cycle.
// The datapath holds four bit-serial divider pipelines of 64 stages each.
// Results are presented for one cycle with done; the receiver cannot stall.
// Reset clears all valid bits and configuration registers to zero.
module range_remap_gain_bias (
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic                             start,
    output logic                             busy,
    input  logic signed [rrgb_pkg::SW-1:0]   sample_in,
    input  logic                             last_in,
    output logic                             done,
    output logic signed [rrgb_pkg::SW-1:0]   sample_out,
    output logic                             last_out,
    input  logic                             psel,
    input  logic                             penable,
    input  logic                             pwrite,
    input  logic [rrgb_pkg::ADDR_W-1:0]      paddr,
    input  logic [rrgb_pkg::DATA_W-1:0]      pwdata,
    output logic [rrgb_pkg::DATA_W-1:0]      prdata,
    output logic                             pready
);

    localparam int SW  = rrgb_pkg::SW;
    localparam int CW  = rrgb_pkg::CW;
    localparam int XW  = rrgb_pkg::XW;
    localparam int VW  = rrgb_pkg::VW;
    localparam int F   = rrgb_pkg::FRAC_BITS;
    localparam int QW  = rrgb_pkg::DIV_QW;
    localparam int DW  = rrgb_pkg::DIV_DW;
    localparam int NW  = rrgb_pkg::DIV_NW;
    localparam int DLO = SW / 2;
    localparam int DHI = SW - DLO;
    localparam int ML  = 22;
    localparam int MH  = CW + 1 - ML;
    localparam int PRW = XW + CW + 2;

    rrgb_pkg::cfg_t cfg;

    rrgb_regs u_regs (
        .clk     (clk),
        .rst_n   (rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .cfg     (cfg)
    );

    assign busy = 1'b0;

    // ---------------- stage A: capture ----------------
    logic                 valid_a_reg;
    logic [SW-1:0]        x_a_reg;
    logic                 last_a_reg;

    logic signed [SW:0]   d_a;
    logic signed [CW:0]   r_a;
    logic signed [CW:0]   rng_a;
    logic [SW-1:0]        dmag_a;
    logic [CW:0]          rmag_a;
    logic [CW:0]          rngmag_a;
    rrgb_pkg::side_t      side_a;
    logic [CW:0]          mult_a;

    always_comb
    begin
        d_a      = $signed({x_a_reg[SW-1], x_a_reg}) - (SW + 1)'(rrgb_pkg::sx_cfg(cfg.in_low));
        r_a      = $signed({cfg.in_high[CW-1], cfg.in_high})
                 - $signed({cfg.in_low[CW-1], cfg.in_low});
        rng_a    = $signed({cfg.out_high[CW-1], cfg.out_high})
                 - $signed({cfg.out_low[CW-1], cfg.out_low});
        dmag_a   = d_a[SW] ? SW'(-d_a) : SW'(d_a);
        rmag_a   = r_a[CW] ? (CW + 1)'(-r_a) : (CW + 1)'(r_a);
        rngmag_a = rng_a[CW] ? (CW + 1)'(-rng_a) : (CW + 1)'(rng_a);

        side_a          = '0;
        side_a.last     = last_a_reg;
        side_a.narrow   = rmag_a < (CW + 1)'(rrgb_pkg::EPS);
        side_a.interior = (d_a != '0) && (d_a[SW] == r_a[CW]) && (dmag_a < SW'(rmag_a));
        side_a.neg      = !side_a.interior && (d_a[SW] ^ r_a[CW] ^ rng_a[CW]);
        // interior samples divide d*ONE by r, the rest d*R by r
        mult_a          = side_a.interior ? (CW + 1)'(rrgb_pkg::ONE) : rngmag_a;
    end

    // ---------------- stage B: partial products ----------------
    logic                 valid_b_reg;
    logic [SW-1:0]        dmag_b_reg;
    logic [CW:0]          mult_b_reg;
    logic [CW:0]          rmag_b_reg;
    rrgb_pkg::side_t      side_b_reg;

    logic                 valid_c_reg;
    logic [DLO+ML-1:0]    pp0_c_reg;
    logic [DLO+MH-1:0]    pp1_c_reg;
    logic [DHI+ML-1:0]    pp2_c_reg;
    logic [DHI+MH-1:0]    pp3_c_reg;
    logic [CW:0]          rmag_c_reg;
    rrgb_pkg::side_t      side_c_reg;
    logic [NW-1:0]        num_c;

    assign num_c = NW'(pp0_c_reg) + (NW'(pp1_c_reg) << ML) + (NW'(pp2_c_reg) << DLO)
                 + (NW'(pp3_c_reg) << (DLO + ML));

    // ---------------- divider 1 ----------------
    logic                 v1;
    logic [QW-1:0]        quo1;
    logic [DW-1:0]        rem1;
    logic                 ovf1;
    rrgb_pkg::side_t      side1;

    rrgb_div u_div_main (
        .clk       (clk),
        .rst_n     (rst_n),
        .valid_in  (valid_c_reg),
        .num       (num_c),
        .den       (DW'(rmag_c_reg)),
        .side_in   (side_c_reg),
        .valid_out (v1),
        .quo       (quo1),
        .rem       (rem1),
        .ovf       (ovf1),
        .side_out  (side1)
    );

    // ---------------- stage D: floor and saturate ----------------
    logic [QW-1:0]          mag_d;
    logic signed [VW-1:0]   magv_d;
    rrgb_pkg::side_t        side_d_next;
    logic                   valid_d_reg;
    rrgb_pkg::side_t        side_d_reg;

    always_comb
    begin
        if (ovf1 || quo1 > rrgb_pkg::VSAT)
            mag_d = rrgb_pkg::VSAT;
        else
            mag_d = quo1 + QW'(side1.neg && (rem1 != '0));
        magv_d          = $signed(VW'(mag_d));
        side_d_next     = side1;
        side_d_next.val = side1.neg ? -magv_d : magv_d;
        side_d_next.n   = quo1[F-1:0];
    end

    // ---------------- shaping curves ----------------
    logic [XW-1:0]    g_c;
    logic [XW-1:0]    b_c;
    logic             glow;
    logic             cv1;
    logic [XW-1:0]    y1;
    rrgb_pkg::side_t  cside1;
    logic             cv2;
    logic [XW-1:0]    y2;
    rrgb_pkg::side_t  cside2;

    assign g_c  = rrgb_pkg::clamp_one(cfg.gain);
    assign b_c  = rrgb_pkg::clamp_one(cfg.bias);
    assign glow = g_c < rrgb_pkg::HALF;

    rrgb_curve u_curve_first (
        .clk       (clk),
        .rst_n     (rst_n),
        .valid_in  (valid_d_reg),
        .x         (XW'(side_d_reg.n)),
        .side_in   (side_d_reg),
        .sch       (!glow),
        .param     (glow ? b_c : g_c),
        .valid_out (cv1),
        .y         (y1),
        .side_out  (cside1)
    );

    rrgb_curve u_curve_second (
        .clk       (clk),
        .rst_n     (rst_n),
        .valid_in  (cv1),
        .x         (y1),
        .side_in   (cside1),
        .sch       (glow),
        .param     (glow ? g_c : b_c),
        .valid_out (cv2),
        .y         (y2),
        .side_out  (cside2)
    );

    // ---------------- stage E: end points, scale products ----------------
    logic [XW-1:0]          n_e;
    logic [XW-1:0]          s_e_next;
    logic                   valid_e_reg;
    logic [XW-1:0]          s_e_reg;
    rrgb_pkg::side_t        side_e_reg;
    logic signed [CW:0]     rng_e;

    logic                   valid_f_reg;
    logic [XW+ML-1:0]       pl_f_reg;
    logic signed [XW+MH:0]  ph_f_reg;
    rrgb_pkg::side_t        side_f_reg;

    always_comb
    begin
        n_e = XW'(cside2.n);
        if (n_e > rrgb_pkg::T999)
            s_e_next = rrgb_pkg::ONE;
        else if (n_e < rrgb_pkg::EPS)
            s_e_next = '0;
        else
            s_e_next = y2;
        rng_e = $signed({cfg.out_high[CW-1], cfg.out_high})
              - $signed({cfg.out_low[CW-1], cfg.out_low});
    end

    // ---------------- stage F: sum and select ----------------
    logic signed [PRW-1:0]  ph_ext;
    logic signed [PRW-1:0]  prod_f;
    logic signed [PRW-1:0]  scaled_f;
    logic signed [VW-1:0]   ol_f;
    logic signed [VW-1:0]   v_f;

    always_comb
    begin
        ph_ext   = PRW'(ph_f_reg);
        prod_f   = $signed(PRW'(pl_f_reg)) + (ph_ext <<< ML);
        scaled_f = prod_f >>> F;
        ol_f     = rrgb_pkg::sx_cfg(cfg.out_low);
        if (side_f_reg.narrow)
            v_f = ol_f;
        else if (side_f_reg.interior)
            v_f = ol_f + VW'(scaled_f);
        else
            v_f = ol_f + $signed(side_f_reg.val);
    end

    // ---------------- stage G: clamp, prepare wrap ----------------
    logic                   valid_g_reg;
    logic signed [VW-1:0]   v_g_reg;
    rrgb_pkg::side_t        side_g_reg;

    logic signed [VW-1:0]   ol_g;
    logic signed [VW-1:0]   oh_g;
    logic signed [VW-1:0]   mn_g;
    logic signed [VW-1:0]   mx_g;
    logic signed [VW-1:0]   m_g;
    logic                   big_g;
    logic signed [VW-1:0]   clampv_g;
    logic signed [VW-1:0]   t_g;
    logic [QW-1:0]          tmag_g;
    logic                   is_wrap;
    logic                   is_clamp;
    rrgb_pkg::side_t        side_g_next;

    always_comb
    begin
        ol_g     = rrgb_pkg::sx_cfg(cfg.out_low);
        oh_g     = rrgb_pkg::sx_cfg(cfg.out_high);
        mn_g     = (ol_g < oh_g) ? ol_g : oh_g;
        mx_g     = (ol_g < oh_g) ? oh_g : ol_g;
        m_g      = mx_g - mn_g;
        big_g    = m_g > $signed(VW'(rrgb_pkg::EPS));
        is_wrap  = cfg.mode == rrgb_pkg::MODE_WRAP;
        is_clamp = cfg.mode == rrgb_pkg::MODE_CLAMP;
        if (v_g_reg < mn_g)
            clampv_g = mn_g;
        else if (v_g_reg > mx_g)
            clampv_g = mx_g;
        else
            clampv_g = v_g_reg;
        t_g    = v_g_reg - mn_g;
        tmag_g = t_g[VW-1] ? QW'(-t_g) : QW'(t_g);

        side_g_next       = side_g_reg;
        side_g_next.neg   = t_g[VW-1];
        side_g_next.domod = !side_g_reg.narrow && is_wrap && big_g;
        if (side_g_reg.narrow)
            side_g_next.val = v_g_reg;
        else if (is_wrap)
            side_g_next.val = mn_g;
        else if (is_clamp)
            side_g_next.val = clampv_g;
        else
            side_g_next.val = v_g_reg;
    end

    logic                 vm;
    logic [QW-1:0]        quom;
    logic [DW-1:0]        remm;
    logic                 ovfm;
    rrgb_pkg::side_t      sidem;

    rrgb_div u_div_wrap (
        .clk       (clk),
        .rst_n     (rst_n),
        .valid_in  (valid_g_reg),
        .num       (NW'(tmag_g)),
        .den       (DW'(m_g)),
        .side_in   (side_g_next),
        .valid_out (vm),
        .quo       (quom),
        .rem       (remm),
        .ovf       (ovfm),
        .side_out  (sidem)
    );

    // ---------------- output stage: floored residue, saturate ----------------
    logic signed [VW-1:0]   ol_h;
    logic signed [VW-1:0]   oh_h;
    logic signed [VW-1:0]   mn_h;
    logic signed [VW-1:0]   m_h;
    logic signed [VW-1:0]   remv_h;
    logic signed [VW-1:0]   res_h;
    logic signed [VW-1:0]   outv_h;
    logic [SW-1:0]          sample_next;

    logic                   done_reg;
    logic [SW-1:0]          sample_out_reg;
    logic                   last_out_reg;

    always_comb
    begin
        ol_h   = rrgb_pkg::sx_cfg(cfg.out_low);
        oh_h   = rrgb_pkg::sx_cfg(cfg.out_high);
        mn_h   = (ol_h < oh_h) ? ol_h : oh_h;
        m_h    = ((ol_h < oh_h) ? oh_h : ol_h) - mn_h;
        remv_h = $signed(VW'(remm));
        // a negative offset with a nonzero residue wraps back from the top
        res_h  = (sidem.neg && (remm != '0)) ? m_h - remv_h : remv_h;
        outv_h = sidem.domod ? mn_h + res_h : $signed(sidem.val);
        if (outv_h > rrgb_pkg::S48_MAX)
            sample_next = SW'(rrgb_pkg::S48_MAX);
        else if (outv_h < rrgb_pkg::S48_MIN)
            sample_next = SW'(rrgb_pkg::S48_MIN);
        else
            sample_next = SW'(outv_h);
    end

    // ---------------- pipeline registers ----------------
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_a_reg <= 1'b0;
            valid_b_reg <= 1'b0;
            valid_c_reg <= 1'b0;
            valid_d_reg <= 1'b0;
            valid_e_reg <= 1'b0;
            valid_f_reg <= 1'b0;
            valid_g_reg <= 1'b0;
            done_reg    <= 1'b0;
        end
        else
        begin
            valid_a_reg <= start && !busy;
            valid_b_reg <= valid_a_reg;
            valid_c_reg <= valid_b_reg;
            valid_d_reg <= v1;
            valid_e_reg <= cv2;
            valid_f_reg <= valid_e_reg;
            valid_g_reg <= valid_f_reg;
            done_reg    <= vm;
        end
    end

    always_ff @(posedge clk)
    begin
        x_a_reg        <= sample_in;
        last_a_reg     <= last_in;
        dmag_b_reg     <= dmag_a;
        mult_b_reg     <= mult_a;
        rmag_b_reg     <= rmag_a;
        side_b_reg     <= side_a;
        pp0_c_reg      <= dmag_b_reg[DLO-1:0] * mult_b_reg[ML-1:0];
        pp1_c_reg      <= dmag_b_reg[DLO-1:0] * mult_b_reg[CW:ML];
        pp2_c_reg      <= dmag_b_reg[SW-1:DLO] * mult_b_reg[ML-1:0];
        pp3_c_reg      <= dmag_b_reg[SW-1:DLO] * mult_b_reg[CW:ML];
        rmag_c_reg     <= rmag_b_reg;
        side_c_reg     <= side_b_reg;
        side_d_reg     <= side_d_next;
        s_e_reg        <= s_e_next;
        side_e_reg     <= cside2;
        pl_f_reg       <= s_e_reg * rng_e[ML-1:0];
        ph_f_reg       <= $signed({1'b0, s_e_reg}) * $signed(rng_e[CW:ML]);
        side_f_reg     <= side_e_reg;
        v_g_reg        <= v_f;
        side_g_reg     <= side_f_reg;
        sample_out_reg <= sample_next;
        last_out_reg   <= sidem.last;
    end

    assign done       = done_reg;
    assign sample_out = sample_out_reg;
    assign last_out   = last_out_reg;

    a_wrap_residue: assert property (@(posedge clk) disable iff (!rst_n)
        (vm && sidem.domod) |-> ((res_h >= 0) && (res_h < m_h)))
        else $error("wrapped residue outside the output span");

    a_narrow_low: assert property (@(posedge clk) disable iff (!rst_n)
        (valid_g_reg && side_g_reg.narrow) |-> (v_g_reg == rrgb_pkg::sx_cfg(cfg.out_low)))
        else $error("narrow input range did not select out_low");

endmodule
